// ===== sv/btm_pkg.sv =====
// Shared command codes, channel widths and controller/datapath interface types.
package btm_pkg;

   // Program characters
   localparam logic [7:0] CMD_INC   = 8'h2B;  // '+'
   localparam logic [7:0] CMD_DEC   = 8'h2D;  // '-'
   localparam logic [7:0] CMD_RIGHT = 8'h3E;  // '>'
   localparam logic [7:0] CMD_LEFT  = 8'h3C;  // '<'
   localparam logic [7:0] CMD_OUT   = 8'h2E;  // '.'
   localparam logic [7:0] CMD_IN    = 8'h2C;  // ','
   localparam logic [7:0] CMD_MUL   = 8'h2A;  // '*'
   localparam logic [7:0] CMD_DIV   = 8'h2F;  // '/'
   localparam logic [7:0] CMD_SKIP  = 8'h40;  // '@'
   localparam logic [7:0] CMD_OR    = 8'h5F;  // '_'
   localparam logic [7:0] CMD_AND   = 8'h60;  // '`'
   localparam logic [7:0] CMD_XOR   = 8'h3B;  // ';'

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 3;

   localparam int USER_OUT_VALID   = 0;
   localparam int USER_DIV_BY_ZERO = 1;
   localparam int USER_WAS_SKIPPED = 2;

   // Step strobes from the controller
   typedef struct packed {
      logic capture;
      logic decode;
      logic read_a;
      logic read_b;
      logic div_write;
      logic load_rsp;
      logic clear;
   } btm_cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic skip_pending;
      logic needs_read;
      logic is_binop;
      logic is_div;
      logic b_zero;
      logic div_done;
      logic clear_last;
   } btm_status_type;

endpackage

// ===== sv/btm_div.sv =====
// Restoring 8-bit unsigned divider, one quotient bit per cycle.
module btm_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [7:0] divisor,
   output logic       done,
   output logic [7:0] quotient
);
   import btm_pkg::*;

   logic [7:0] rem_ff, rem_in;
   logic [7:0] quo_ff, quo_in;
   logic [7:0] dvs_ff, dvs_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [8:0] trial;
   logic [8:0] diff;

   assign trial = {rem_ff, quo_ff[7]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[7:0];
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/btm_datapath.sv =====
// Tape memory, cell pointer, skip counter, operand ALU and result register.
module btm_datapath #(
   parameter int TAPE_CELLS = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  btm_pkg::btm_cmd_type                cmd,
   output btm_pkg::btm_status_type             status,
   input  logic [btm_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic [btm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [btm_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import btm_pkg::*;

   localparam int PtrWidth = $clog2(TAPE_CELLS);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(TAPE_CELLS - 1);
   localparam logic [PtrWidth-1:0] PtrEdge = PtrWidth'(TAPE_CELLS - 2);

   logic [7:0] tape_mem [TAPE_CELLS];
   logic [7:0] rd_data_ff;

   logic [PtrWidth-1:0] ptr_ff, ptr_in;
   logic [PtrWidth-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0]          skip_ff, skip_in;
   logic [7:0]          op_ff, op_in;
   logic [7:0]          inb_ff, inb_in;
   logic [7:0]          a_ff, a_in;
   logic [7:0]          ob_ff, ob_in;
   logic                ov_ff, ov_in;
   logic                dz_ff, dz_in;
   logic                sk_ff, sk_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                is_binop;
   logic                is_div;
   logic                needs_read;
   logic                skip_pending;
   logic                b_zero;
   logic [PtrWidth-1:0] ptr_plus1;
   logic [PtrWidth-1:0] ptr_minus1;
   logic [PtrWidth-1:0] ptr_eff;
   logic [PtrWidth-1:0] rd_addr;
   logic                wr_en;
   logic [PtrWidth-1:0] wr_addr;
   logic [7:0]          wr_data;
   logic [15:0]         product;
   logic [7:0]          alu_out;
   logic                div_start;
   logic                div_done;
   logic [7:0]          div_quo;

   assign is_binop = (op_ff == CMD_MUL) || (op_ff == CMD_DIV) || (op_ff == CMD_OR) ||
                     (op_ff == CMD_AND) || (op_ff == CMD_XOR);
   assign is_div       = (op_ff == CMD_DIV);
   assign needs_read   = is_binop || (op_ff == CMD_INC) || (op_ff == CMD_DEC) ||
                         (op_ff == CMD_OUT) || (op_ff == CMD_SKIP);
   assign skip_pending = (skip_ff != 8'd0);
   assign b_zero       = (rd_data_ff == 8'd0);

   assign ptr_plus1  = (ptr_ff == PtrLast) ? '0 : ptr_ff + PtrWidth'(1);
   assign ptr_minus1 = (ptr_ff == '0) ? PtrLast : ptr_ff - PtrWidth'(1);
   // two-operand commands restart at cell 0 when p+2 runs off the tape
   assign ptr_eff    = (is_binop && ptr_ff >= PtrEdge) ? '0 : ptr_ff;
   assign rd_addr    = cmd.read_a ? ptr_ff + PtrWidth'(1) : ptr_eff;

   assign product = a_ff * rd_data_ff;

   always_comb begin
      unique case (op_ff)
         CMD_MUL: alu_out = product[7:0];
         CMD_OR:  alu_out = a_ff | rd_data_ff;
         CMD_AND: alu_out = a_ff & rd_data_ff;
         CMD_XOR: alu_out = a_ff ^ rd_data_ff;
         default: alu_out = 8'd0;  // divide by zero writes zero
      endcase
   end

   assign div_start = cmd.read_b && is_div && !b_zero;

   btm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (rd_data_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = 8'd0;
      priority if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (cmd.decode && !skip_pending && op_ff == CMD_IN) begin
         wr_en   = 1'b1;
         wr_data = inb_ff;
      end else if (cmd.read_a && op_ff == CMD_INC) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff + 8'd1;
      end else if (cmd.read_a && op_ff == CMD_DEC) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff - 8'd1;
      end else if (cmd.read_b && !div_start) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff + PtrWidth'(2);
         wr_data = alu_out;
      end else if (cmd.div_write) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff + PtrWidth'(2);
         wr_data = div_quo;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tape_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tape_mem[rd_addr];
   end

   always_comb begin
      ptr_in      = ptr_ff;
      skip_in     = skip_ff;
      clr_cnt_in  = clr_cnt_ff;
      op_in       = op_ff;
      inb_in      = inb_ff;
      a_in        = a_ff;
      ob_in       = ob_ff;
      ov_in       = ov_ff;
      dz_in       = dz_ff;
      sk_in       = sk_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      if (cmd.clear && clr_cnt_ff != PtrLast) begin
         clr_cnt_in = clr_cnt_ff + PtrWidth'(1);
      end
      if (cmd.capture) begin
         op_in  = req_tdata[7:0];
         inb_in = req_tdata[15:8];
         ob_in  = 8'd0;
         ov_in  = 1'b0;
         dz_in  = 1'b0;
         sk_in  = 1'b0;
      end
      if (cmd.decode) begin
         if (skip_pending) begin
            skip_in = skip_ff - 8'd1;
            sk_in   = 1'b1;
         end else if (op_ff == CMD_RIGHT) begin
            ptr_in = ptr_plus1;
         end else if (op_ff == CMD_LEFT) begin
            ptr_in = ptr_minus1;
         end else if (is_binop) begin
            ptr_in = ptr_eff;
         end
      end
      if (cmd.read_a) begin
         if (op_ff == CMD_OUT) begin
            ob_in = rd_data_ff;
            ov_in = 1'b1;
         end else if (op_ff == CMD_SKIP) begin
            skip_in = rd_data_ff;
         end
         a_in = rd_data_ff;
      end
      if (cmd.read_b && is_div && b_zero) begin
         dz_in = 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_data_in                   = ob_ff;
         rsp_user_in[USER_OUT_VALID]   = ov_ff;
         rsp_user_in[USER_DIV_BY_ZERO] = dz_ff;
         rsp_user_in[USER_WAS_SKIPPED] = sk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         skip_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         skip_ff    <= skip_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      inb_ff      <= inb_in;
      a_ff        <= a_in;
      ob_ff       <= ob_in;
      ov_ff       <= ov_in;
      dz_ff       <= dz_in;
      sk_ff       <= sk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign status.skip_pending = skip_pending;
   assign status.needs_read   = needs_read;
   assign status.is_binop     = is_binop;
   assign status.is_div       = is_div;
   assign status.b_zero       = b_zero;
   assign status.div_done     = div_done;
   assign status.clear_last   = (clr_cnt_ff == PtrLast);

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== sv/btm_ctrl.sv =====
// Sequencer: clearing pass, per-item step control and result handshake.
module btm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output btm_pkg::btm_cmd_type    cmd,
   input  btm_pkg::btm_status_type status
);
   import btm_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_READ_A = 3'd3;
   localparam logic [2:0] ST_READ_B = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (!status.skip_pending && status.needs_read) begin
               state_in = ST_READ_A;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ_A: begin
            cmd.read_a = 1'b1;
            state_in   = status.is_binop ? ST_READ_B : ST_FINISH;
         end
         ST_READ_B: begin
            cmd.read_b = 1'b1;
            state_in   = (status.is_div && !status.b_zero) ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.div_write = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/byte_tape_machine_step_unit.sv =====
// Top level of the byte tape command machine: sequencer plus tape datapath.
//
//   channel | direction | tdata (low bit up)       | tuser (low bit up)
//   req_    | in        | cmd[7:0], in_byte[15:8]  | -
//   rsp_    | out       | out_byte[7:0]            | out_valid, div_by_zero, was_skipped
//
// An item goes from capture through decode to a finish step for pointer moves, ',' and
// skipped items; '+', '-', '.' and '@' add a tape read step, the two-operand commands
// a second read step, and '/' with a nonzero divisor then waits on the bit-serial
// divider. After reset the tape is cleared one cell a cycle with req_tready low. A
// stalled result waits in the output register; the next item is taken meanwhile and
// holds in its last step until that register drains.
module byte_tape_machine_step_unit #(
   parameter int TAPE_CELLS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [btm_pkg::REQ_DATA_W-1:0]     req_tdata,   // cmd, in_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [btm_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // out_byte
   output logic [btm_pkg::RSP_USER_W-1:0]     rsp_tuser    // out_valid, div_by_zero, was_skipped
);
   import btm_pkg::*;

   btm_cmd_type    cmd;
   btm_status_type status;

   btm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   btm_datapath #(
      .TAPE_CELLS (TAPE_CELLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== sv/btm_checker.sv =====
// Port-level checks for the byte tape machine, bound to the top level.
module btm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [btm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [btm_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import btm_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item at a time: no transfer right after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   // a result is at most one of emitted, divide fault, skipped
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tuser))
      else $error("conflicting result flags");

   // the data byte is zero unless the item emitted a cell
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[USER_OUT_VALID] |-> rsp_tdata == '0)
      else $error("nonzero byte on a result that emits nothing");

endmodule

bind byte_tape_machine_step_unit btm_checker u_btm_checker (.*);
